/* rtl/core/trsmm_pkg.sv */
// Shared types, constants and helpers for the TRS model-matrix builder.
package trsmm_pkg;

  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ANGLE_SHIFT     = 30 - ANGLE_FRAC_BITS;

  localparam int CORDIC_STEPS = 30;
  localparam int ZW = 36;           // angle accumulator, Q30
  localparam int XW = 34;           // sine/cosine and matrix terms, Q30
  localparam int PW = 2 * XW;       // full product width

  // reduction (2) + iterations + sign fold (1)
  localparam int CORDIC_LAT = CORDIC_STEPS + 3;
  localparam int MAT_LAT    = 5;
  localparam int TOTAL_LAT  = CORDIC_LAT + MAT_LAT;

  localparam logic signed [ZW-1:0] PI_Q30     = ZW'(64'sd3373259426);
  localparam logic signed [ZW-1:0] HALFPI_Q30 = ZW'(64'sd1686629713);
  localparam logic signed [ZW-1:0] TWOPI_Q30  = ZW'(64'sd6746518852);
  localparam logic signed [XW-1:0] GAIN_Q30   = XW'(64'sd652032874);
  localparam logic signed [PW-1:0] HALF_Q30   = PW'(64'sd536870912);

  typedef logic signed [XW-1:0] qv_t;
  typedef logic signed [31:0]   word_t;

  typedef struct packed {
    qv_t sx; qv_t cx;
    qv_t sy; qv_t cy;
    qv_t sz; qv_t cz;
  } trig_t;

  typedef struct packed {
    word_t x; word_t y; word_t z;
  } vec3_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0:       t = ZW'(64'sd843314857);
      1:       t = ZW'(64'sd497837829);
      2:       t = ZW'(64'sd263043837);
      3:       t = ZW'(64'sd133525159);
      4:       t = ZW'(64'sd67021687);
      5:       t = ZW'(64'sd33543516);
      6:       t = ZW'(64'sd16775851);
      7:       t = ZW'(64'sd8388437);
      8:       t = ZW'(64'sd4194283);
      9:       t = ZW'(64'sd2097149);
      10:      t = ZW'(64'sd1048576);
      default: t = ZW'(64'sd1 <<< (30 - i));
    endcase
    return t;
  endfunction

  // Q30 product, round half up
  function automatic qv_t mulq(input qv_t a, input qv_t b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b);
    p = p + HALF_Q30;
    return XW'(p >>> 30);
  endfunction

endpackage

/* rtl/core/trsmm_cordic.sv */
// Pipelined rotation-mode CORDIC giving sine and cosine of one Q3.13 angle.
module trsmm_cordic (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [15:0]            angle,
  output trsmm_pkg::qv_t                sin_o,
  output trsmm_pkg::qv_t                cos_o
);
  import trsmm_pkg::*;

  logic signed [ZW-1:0] a0, a1_nxt, a2_nxt;
  logic signed [ZW-1:0] a1_r;
  logic                 flip2_nxt;

  logic signed [ZW-1:0] z_r [0:CORDIC_STEPS];
  qv_t                  x_r [0:CORDIC_STEPS];
  qv_t                  y_r [0:CORDIC_STEPS];
  logic                 f_r [0:CORDIC_STEPS];
  qv_t                  sin_r, cos_r;

  // wrap into (-pi, pi]
  always_comb begin
    a0 = ZW'(angle) <<< ANGLE_SHIFT;
    if (a0 > PI_Q30) begin
      a1_nxt = a0 - TWOPI_Q30;
    end else if (a0 <= -PI_Q30) begin
      a1_nxt = a0 + TWOPI_Q30;
    end else begin
      a1_nxt = a0;
    end
  end

  // fold into [-pi/2, pi/2]
  always_comb begin
    flip2_nxt = 1'b1;
    if (a1_r > HALFPI_Q30) begin
      a2_nxt = a1_r - PI_Q30;
    end else if (a1_r < -HALFPI_Q30) begin
      a2_nxt = a1_r + PI_Q30;
    end else begin
      a2_nxt    = a1_r;
      flip2_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= a1_nxt;
      z_r[0] <= a2_nxt;
      x_r[0] <= GAIN_Q30;
      y_r[0] <= '0;
      f_r[0] <= flip2_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] T = atan_q30(i);
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i+1] <= f_r[i];
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - T;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + T;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= f_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
      sin_r <= f_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
    end
  end

  // final residual angle is not needed
  logic unused_z;
  assign unused_z = ^z_r[CORDIC_STEPS];

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

/* rtl/core/trsmm_matrix.sv */
// Rotation product, column scaling, rounding and saturation pipeline.
module trsmm_matrix (
  input  logic              clk,
  input  logic              en,
  input  trsmm_pkg::trig_t  trig,
  input  trsmm_pkg::vec3_t  scale,
  output trsmm_pkg::word_t  m_o [9]
);
  import trsmm_pkg::*;

  // stage A: first-level products
  qv_t sxsy_r, cxsy_r, cycz_r, cysz_r, cxcz_r, cxsz_r, sxsz_r, sxcz_r, sxcy_r, cxcy_r;
  qv_t sya_r, sza_r, cza_r;
  // stage B
  qv_t sxsycz_r, sxsysz_r, cxsycz_r, cxsysz_r;
  qv_t cyczb_r, cyszb_r, cxczb_r, cxszb_r, sxszb_r, sxczb_r, sxcyb_r, cxcyb_r, syb_r;
  // stage C, D, E
  qv_t                  r_r   [9];
  logic signed [PW-1:0] prd_r [9];
  word_t                m_r   [9];
  vec3_t                sca_r, scb_r, scc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sxsy_r <= mulq(trig.sx, trig.sy);
      cxsy_r <= mulq(trig.cx, trig.sy);
      cycz_r <= mulq(trig.cy, trig.cz);
      cysz_r <= mulq(trig.cy, trig.sz);
      cxcz_r <= mulq(trig.cx, trig.cz);
      cxsz_r <= mulq(trig.cx, trig.sz);
      sxsz_r <= mulq(trig.sx, trig.sz);
      sxcz_r <= mulq(trig.sx, trig.cz);
      sxcy_r <= mulq(trig.sx, trig.cy);
      cxcy_r <= mulq(trig.cx, trig.cy);
      sya_r  <= trig.sy;
      sza_r  <= trig.sz;
      cza_r  <= trig.cz;
      sca_r  <= scale;

      sxsycz_r <= mulq(sxsy_r, cza_r);
      sxsysz_r <= mulq(sxsy_r, sza_r);
      cxsycz_r <= mulq(cxsy_r, cza_r);
      cxsysz_r <= mulq(cxsy_r, sza_r);
      cyczb_r  <= cycz_r;
      cyszb_r  <= cysz_r;
      cxczb_r  <= cxcz_r;
      cxszb_r  <= cxsz_r;
      sxszb_r  <= sxsz_r;
      sxczb_r  <= sxcz_r;
      sxcyb_r  <= sxcy_r;
      cxcyb_r  <= cxcy_r;
      syb_r    <= sya_r;
      scb_r    <= sca_r;

      r_r[0] <= cyczb_r;
      r_r[1] <= -cyszb_r;
      r_r[2] <= syb_r;
      r_r[3] <= sxsycz_r + cxszb_r;
      r_r[4] <= cxczb_r - sxsysz_r;
      r_r[5] <= -sxcyb_r;
      r_r[6] <= sxszb_r - cxsycz_r;
      r_r[7] <= cxsysz_r + sxczb_r;
      r_r[8] <= cxcyb_r;
      scc_r  <= scb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prd_r[3*r+0] <= PW'(r_r[3*r+0]) * PW'(scc_r.x);
        prd_r[3*r+1] <= PW'(r_r[3*r+1]) * PW'(scc_r.y);
        prd_r[3*r+2] <= PW'(r_r[3*r+2]) * PW'(scc_r.z);
      end
    end
  end

  localparam logic signed [ZW-1:0] SAT_HI = ZW'(64'sd2147483647);
  localparam logic signed [ZW-1:0] SAT_LO = -ZW'(64'sd2147483648);

  logic signed [ZW-1:0] rnd [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      rnd[k] = ZW'((prd_r[k] + HALF_Q30) >>> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        if (rnd[k] > SAT_HI) begin
          m_r[k] <= 32'sh7fffffff;
        end else if (rnd[k] < SAT_LO) begin
          m_r[k] <= 32'sh80000000;
        end else begin
          m_r[k] <= 32'(rnd[k]);
        end
      end
    end
  end

  assign m_o = m_r;

endmodule

/* rtl/core/trs_model_matrix_builder_unit.sv */
// Top level of the TRS model-matrix builder: three CORDIC pipes, matrix pipe, stream ports.
//
// Builds the top three rows of M = T(pos) * Rx * Ry * Rz * S(scale) for one request per
// clock while the output is not back-pressured. The CORDIC has two angle reduction
// stages, thirty iteration stages and one sign fold; the matrix pipe has two product
// levels, the row sums, the scale multiply and the round/saturate output register.
// The whole pipe advances as one: it moves whenever the output register is empty or
// being taken, so a back-pressured result stalls every stage and nothing is lost or
// repeated. Rotation and scale terms are Q16.16 saturated; the fourth column is the
// position passed through. No state, no configuration.
module trs_model_matrix_builder_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, pos_z (32b), angle_x, angle_y, angle_z (16b), scale_x, scale_y,
  // scale_z (32b), lowest bits first
  input  logic [239:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // m00 m01 m02 m03 m10 m11 m12 m13 m20 m21 m22 m23, 32b each, lowest bits first
  output logic [383:0] out_tdata
);
  import trsmm_pkg::*;

  logic  en;
  logic  vld_r [TOTAL_LAT];
  vec3_t pos_in, scl_in;
  vec3_t pos_dly_r [TOTAL_LAT];
  vec3_t scl_dly_r [CORDIC_LAT];
  trig_t trig;
  word_t m [9];

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  assign pos_in = '{x: in_tdata[31:0],    y: in_tdata[63:32],   z: in_tdata[95:64]};
  assign scl_in = '{x: in_tdata[175:144], y: in_tdata[207:176], z: in_tdata[239:208]};

  trsmm_cordic u_cordic_x (
    .clk(clk), .en(en), .angle(in_tdata[111:96]), .sin_o(trig.sx), .cos_o(trig.cx)
  );
  trsmm_cordic u_cordic_y (
    .clk(clk), .en(en), .angle(in_tdata[127:112]), .sin_o(trig.sy), .cos_o(trig.cy)
  );
  trsmm_cordic u_cordic_z (
    .clk(clk), .en(en), .angle(in_tdata[143:128]), .sin_o(trig.sz), .cos_o(trig.cz)
  );

  trsmm_matrix u_matrix (
    .clk(clk), .en(en), .trig(trig), .scale(scl_dly_r[CORDIC_LAT-1]), .m_o(m)
  );

  // valid bits travel with the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TOTAL_LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < TOTAL_LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // side data delay lines
  always_ff @(posedge clk) begin
    if (en) begin
      pos_dly_r[0] <= pos_in;
      for (int k = 1; k < TOTAL_LAT; k++) pos_dly_r[k] <= pos_dly_r[k-1];
      scl_dly_r[0] <= scl_in;
      for (int k = 1; k < CORDIC_LAT; k++) scl_dly_r[k] <= scl_dly_r[k-1];
    end
  end

  assign out_tvalid = vld_r[TOTAL_LAT-1];
  assign out_tdata  = {pos_dly_r[TOTAL_LAT-1].z, m[8], m[7], m[6],
                       pos_dly_r[TOTAL_LAT-1].y, m[5], m[4], m[3],
                       pos_dly_r[TOTAL_LAT-1].x, m[2], m[1], m[0]};

endmodule

/* rtl/core/trsmm_checker.sv */
// Port-level checks for the TRS model-matrix builder, bound to the top level.
module trsmm_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [383:0] out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown straight after reset");

  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output drain");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("stalled result changed");

  logic unused_in;
  assign unused_in = in_tvalid;

endmodule

bind trs_model_matrix_builder_unit trsmm_checker u_trsmm_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

/* tb/sv/trs_model_matrix_builder_unit_test.sv */
// Self-checking stream testbench for the TRS model-matrix builder.
module trs_model_matrix_builder_unit_test;

  localparam int PIPE_LAT   = 38;
  localparam int IDLE_PCT   = 29;
  localparam int N_RANDOM   = 1880;
  localparam int STALL_CAP  = 20000;
  localparam int MAX_REPORT = 10;

  // angle constants in Q3.13 (pi ~ 25736, pi/2 ~ 12868)
  localparam logic signed [15:0] ANG_PI     = 16'sd25736;
  localparam logic signed [15:0] ANG_HALFPI = 16'sd12868;

  typedef struct packed {
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [15:0] ang_x, ang_y, ang_z;
    logic signed [31:0] scl_x, scl_y, scl_z;
  } xform_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [239:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [383:0] out_tdata;

  logic [383:0] matrix_q[$];
  xform_t       pending_q[$];
  int           mismatches;
  int           idle_cycles;
  bit           quiet_phase;
  bit           timed_out;

  trs_model_matrix_builder_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // lowest bits first: pos, angles, scales
  function automatic logic [239:0] pack_xform(input xform_t t);
    return {t.scl_z, t.scl_y, t.scl_x, t.ang_z, t.ang_y, t.ang_x, t.pos_z, t.pos_y, t.pos_x};
  endfunction

  function automatic logic signed [63:0] shr_floor(input logic signed [63:0] v, input int s);
    return v >>> s;
  endfunction

  function automatic logic signed [63:0] q30_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // rotation-mode CORDIC, Q30, with fold into +-pi/2
  task automatic cordic_sincos(input logic signed [15:0] ang,
                               output logic signed [63:0] s, output logic signed [63:0] c);
    logic signed [63:0] a, x, y, z, dx, dy, t;
    logic signed [63:0] atab [0:10];
    bit flip;
    atab = '{64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159, 64'sd67021687,
             64'sd33543516, 64'sd16775851, 64'sd8388437, 64'sd4194283, 64'sd2097149,
             64'sd1048576};
    flip = 0;
    a = 64'(ang) * (64'sd1 <<< 17);
    a = (a + 64 * 64'sd6746518852) % 64'sd6746518852;
    if (a > 64'sd3373259426) a = a - 64'sd6746518852;
    if (a > 64'sd1686629713) begin
      a = a - 64'sd3373259426;
      flip = 1;
    end else if (a < -64'sd1686629713) begin
      a = a + 64'sd3373259426;
      flip = 1;
    end
    x = 64'sd652032874;
    y = 0;
    z = a;
    for (int i = 0; i < 30; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      t  = (i < 11) ? atab[i] : (64'sd1 <<< (30 - i));
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - t;
      end else begin
        x = x + dx; y = y - dy; z = z + t;
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endtask

  task automatic build_matrix(input xform_t t, output logic [383:0] m);
    logic signed [63:0] sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    logic signed [63:0] r [0:8];
    logic signed [63:0] scl [0:2];
    logic signed [31:0] pos [0:2];
    cordic_sincos(t.ang_x, sx, cx);
    cordic_sincos(t.ang_y, sy, cy);
    cordic_sincos(t.ang_z, sz, cz);
    sxsy = q30_mul(sx, sy);
    cxsy = q30_mul(cx, sy);
    r[0] = q30_mul(cy, cz);
    r[1] = -q30_mul(cy, sz);
    r[2] = sy;
    r[3] = q30_mul(sxsy, cz) + q30_mul(cx, sz);
    r[4] = q30_mul(cx, cz) - q30_mul(sxsy, sz);
    r[5] = -q30_mul(sx, cy);
    r[6] = q30_mul(sx, sz) - q30_mul(cxsy, cz);
    r[7] = q30_mul(cxsy, sz) + q30_mul(sx, cz);
    r[8] = q30_mul(cx, cy);
    scl = '{64'(t.scl_x), 64'(t.scl_y), 64'(t.scl_z)};
    pos = '{t.pos_x, t.pos_y, t.pos_z};
    for (int row = 0; row < 3; row++) begin
      for (int col = 0; col < 3; col++)
        m[(row*4+col)*32 +: 32] = clamp32(q30_mul(r[row*3+col], scl[col]));
      m[(row*4+3)*32 +: 32] = pos[row];
    end
  endtask

  function automatic xform_t random_xform();
    xform_t t;
    int sel;
    t = {$urandom, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
         $urandom, $urandom, $urandom};
    sel = $urandom_range(0, 3);
    // mostly unit-ish scales so the rotation terms are not all saturated
    if (sel != 0) begin
      t.scl_x = $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh0002_0000;
      t.scl_y = $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh0002_0000;
      t.scl_z = $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh0002_0000;
    end
    if (sel == 1) begin
      t.ang_x = $signed(16'($urandom_range(0, 2 * 25736))) - ANG_PI;
      t.ang_y = $signed(16'($urandom_range(0, 2 * 25736))) - ANG_PI;
      t.ang_z = $signed(16'($urandom_range(0, 2 * 25736))) - ANG_PI;
    end
    return t;
  endfunction

  // request driver; golden row given where it is plain (zero scale)
  initial begin : stim
    xform_t      t;
    xform_t      dir_tab [$];
    logic [383:0] dir_gold [$];
    bit          has_gold [$];
    logic [383:0] g;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    rst_n       = 1'b0;
    quiet_phase = 1'b0;

    // zero scale: rotation collapses, translation passes through
    t = '{32'sh7fffffff, 32'sh80000000, 32'sh0001_8000, 16'sh7fff, 16'sh8000, 16'sh1234,
          0, 0, 0};
    dir_tab.push_back(t); has_gold.push_back(1);
    dir_gold.push_back({32'sh0001_8000, 96'h0, 32'sh80000000, 96'h0, 32'sh7fffffff, 96'h0});
    // identity rotation, unit scale
    t = '{32'sh0000_0001, 32'shffff_ffff, 0, 0, 0, 0,
          32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000};
    dir_tab.push_back(t); has_gold.push_back(0); dir_gold.push_back('0);
    // huge scales saturate both ways
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff});
    dir_tab.push_back('{0, 0, 0, ANG_PI, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000});
    // angles at and around the quadrant folds and the field extremes
    dir_tab.push_back('{0, 0, 0, ANG_HALFPI, ANG_HALFPI, ANG_HALFPI,
                        32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000});
    dir_tab.push_back('{0, 0, 0, -ANG_HALFPI, ANG_HALFPI + 1, -ANG_HALFPI - 1,
                        32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000});
    dir_tab.push_back('{0, 0, 0, ANG_PI, -ANG_PI, ANG_PI + 1,
                        32'sh0002_0000, 32'sh0001_0000, 32'sh0000_8000});
    dir_tab.push_back('{0, 0, 0, 16'sh7fff, 16'sh8000, 16'sh0001,
                        32'shffff_0000, 32'sh0001_0000, 32'shfffe_0000});
    dir_tab.push_back('{32'shffffffff, 32'shffffffff, 32'shffffffff, 16'shffff, 16'shffff,
                        16'shffff, 32'shffffffff, 32'shffffffff, 32'shffffffff});
    dir_tab.push_back('{32'sh55555555, 32'shaaaaaaaa, 0, 16'sh5555, 16'shaaaa, 0,
                        32'sh5555_5555, 32'shaaaa_aaaa, 1});
    while (has_gold.size() < dir_tab.size()) begin
      has_gold.push_back(0); dir_gold.push_back('0);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < dir_tab.size() + N_RANDOM; n++) begin
      t = (n < dir_tab.size()) ? dir_tab[n] : random_xform();
      // one hold-off: drain everything before carrying on
      if (n == dir_tab.size() + N_RANDOM / 2) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (matrix_q.size() != 0);
        quiet_phase = 1'b1;
      end
      if (n == dir_tab.size() + 3 * N_RANDOM / 4) quiet_phase = 1'b0;
      while (!quiet_phase && $urandom_range(0, 99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      build_matrix(t, g);
      if (n < dir_tab.size() && has_gold[n] && g != dir_gold[n])
        $display("predictor disagrees with typed row %0d", n);
      if (n < dir_tab.size() && has_gold[n]) g = dir_gold[n];
      in_tvalid <= 1'b1;
      in_tdata  <= pack_xform(t);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      matrix_q.push_back(g);
    end
    in_tvalid <= 1'b0;

    while (matrix_q.size() != 0 && !timed_out) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (!timed_out) begin
      if (mismatches == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
    end
  end

  // result receiver: random back-pressure, quiet during the hold-off stretch
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= quiet_phase || ($urandom_range(0, 99) >= IDLE_PCT);
  end
  initial out_tready = 1'b0;

  // compare each accepted result with the oldest expected matrix
  always @(posedge clk) begin
    logic [383:0] exp_m;
    if (rst_n && out_tvalid && out_tready) begin
      if (matrix_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORT) $display("unexpected result %h", out_tdata);
      end else begin
        exp_m = matrix_q.pop_front();
        for (int f = 0; f < 12; f++)
          if (out_tdata[f*32 +: 32] !== exp_m[f*32 +: 32]) begin
            mismatches++;
            if (mismatches <= MAX_REPORT)
              $display("field m%0d%0d: expected %h got %h", f / 4, f % 4,
                       exp_m[f*32 +: 32], out_tdata[f*32 +: 32]);
          end
      end
    end
  end

  // watchdog on cycles with no accepted request or result
  initial begin
    idle_cycles = 0;
    timed_out   = 1'b0;
    mismatches  = 0;
  end
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_CAP) begin
      timed_out <= 1'b1;
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
